[sv/lcg_pkg.sv]
// ----------------------------------------------------------------------------
// lcg_pkg: shared types and constants of the color grading block
// field widths, arithmetic constants, register map and stage enables
// ----------------------------------------------------------------------------
package lcg_pkg;

  localparam int TABLE_SIDE_DEF = 512;

  localparam int CH_W    = 8;
  localparam int PCT_W   = 7;
  localparam int IDX_W   = 18;
  localparam int ENTRY_W = 3 * CH_W;
  localparam int IN_W    = 96;
  localparam int OUT_W   = 24;
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 32;

  localparam logic [CFG_AW-1:0] REG_INTENSITY = 3'd0;

  localparam logic KIND_TABLE = 1'b0;
  localparam logic KIND_PIXEL = 1'b1;

  localparam logic [CH_W-1:0]  CH_MAX  = 8'd255;
  localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;
  localparam logic [PCT_W-1:0] PCT_RST = 7'd100;

  // reciprocal multipliers, exact over the value ranges that occur
  localparam int DIV3_MUL   = 683;   // x/3   = (x*683)   >> 11, x < 2048
  localparam int DIV255_MUL = 32897; // x/255 = (x*32897) >> 23, x < 66052
  localparam int DIV100_MUL = 5243;  // x/100 = (x*5243)  >> 19, x < 43690

  // load enables of the channel pipeline stages
  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
    logic s5;
    logic s6;
  } stage_en_t;

endpackage

[sv/lcg_cfg.sv]
// ----------------------------------------------------------------------------
// lcg_cfg: configuration register file
// apb write and read of the intensity register, clamped percent output
// ----------------------------------------------------------------------------
module lcg_cfg
  import lcg_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output logic [PCT_W-1:0]  pct
);

  logic [PCT_W-1:0] intensity_r;
  logic [PCT_W-1:0] intensity_nxt;
  logic             hit;

  // low address bits are ignored, so every byte of the word hits
  assign hit    = (paddr[CFG_AW-1:2] == REG_INTENSITY[CFG_AW-1:2]);
  assign pready = 1'b1;

  always_comb begin
    intensity_nxt = intensity_r;
    if (psel && penable && pwrite && hit) begin
      intensity_nxt = pwdata[PCT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      intensity_r <= PCT_RST;
    end else begin
      intensity_r <= intensity_nxt;
    end
  end

  assign prdata = hit ? {{(CFG_DW-PCT_W){1'b0}}, intensity_r} : '0;
  assign pct    = (intensity_r > PCT_MAX) ? PCT_MAX : intensity_r;

endmodule

[sv/lcg_table.sv]
// ----------------------------------------------------------------------------
// lcg_table: grading table memory
// one write port and one read port with registered read data
// ----------------------------------------------------------------------------
module lcg_table
  import lcg_pkg::*;
#(
  parameter int DEPTH = TABLE_SIDE_DEF * TABLE_SIDE_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  logic [ENTRY_W-1:0] wdata,
  input  logic               re,
  input  logic [AW-1:0]      raddr,
  output logic [ENTRY_W-1:0] rdata
);

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[sv/lcg_chan.sv]
// ----------------------------------------------------------------------------
// lcg_chan: one color channel of the blend pipeline
// alpha blend, divide by 255, percent mix, divide by 100 over five stages
// ----------------------------------------------------------------------------
module lcg_chan
  import lcg_pkg::*;
(
  input  logic             clk,
  input  stage_en_t        en,
  input  logic [CH_W-1:0]  src,
  input  logic [CH_W-1:0]  lut,
  input  logic [CH_W-1:0]  alpha,
  input  logic [PCT_W-1:0] pct,
  output logic [CH_W-1:0]  result
);

  logic [CH_W-1:0]  src2_r, lut2_r;
  logic [15:0]      p3_r;
  logic [CH_W-1:0]  src3_r;
  logic [CH_W-1:0]  g4_r, src4_r;
  logic [14:0]      m5_r;
  logic [CH_W-1:0]  out6_r;

  logic [CH_W-1:0]  inv_alpha;
  logic [PCT_W-1:0] inv_pct;
  logic [15:0]      p3_nxt;
  logic [31:0]      div255;
  logic [14:0]      m5_nxt;
  logic [27:0]      div100;

  assign inv_alpha = CH_MAX - alpha;
  assign inv_pct   = PCT_MAX - pct;

  // max 255*255, fits 16 bits
  assign p3_nxt = 16'(src2_r) * 16'(inv_alpha) + 16'(lut2_r) * 16'(alpha);
  assign div255 = 32'(p3_r) * 32'(DIV255_MUL);
  // max 255*100, fits 15 bits
  assign m5_nxt = 15'(g4_r) * 15'(pct) + 15'(src4_r) * 15'(inv_pct);
  assign div100 = 28'(m5_r) * 28'(DIV100_MUL);

  always_ff @(posedge clk) begin
    if (en.s2) begin
      src2_r <= src;
      lut2_r <= lut;
    end
    if (en.s3) begin
      p3_r   <= p3_nxt;
      src3_r <= src2_r;
    end
    if (en.s4) begin
      g4_r   <= div255[30:23];
      src4_r <= src3_r;
    end
    if (en.s5) begin
      m5_r <= m5_nxt;
    end
    if (en.s6) begin
      out6_r <= div100[26:19];
    end
  end

  assign result = out6_r;

endmodule

[sv/lut_color_grade_mask_blend.sv]
// ----------------------------------------------------------------------------
// lut_color_grade_mask_blend: table based color grading with mask blend
// pixels are recolored through a 512x512 grading table and blended
// ----------------------------------------------------------------------------
// usage:
//   in_*  stream carries table loads (in_tuser = 0) and pixels (in_tuser = 1);
//         a load writes one table entry at the accepting edge and gives no beat
//   out_* stream carries one recolored pixel beat per pixel beat, in order
//   cfg_* apb port holds intensity_percent at address 0, write only while idle
// throughput: one beat per clock while out_tready is high, loads and pixels freely mixed
// pipeline: an accepted pixel passes six stages before it leaves; they are
//   table read and mask sum, alpha, blend products, divide by 255,
//   percent mix, divide by 100 (the result register)
// stalls: a full stage holds while the next one holds, so bubbles collapse and
//   in_tready stays high until all six stages hold pixels
// reset: clears the valid bits and sets the intensity to 100 percent;
//   the table is not cleared, a pixel must only hit entries already loaded
// ----------------------------------------------------------------------------
module lut_color_grade_mask_blend
  import lcg_pkg::*;
#(
  parameter int TABLE_SIDE = TABLE_SIDE_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // input stream
  input  logic              in_tvalid,
  output logic              in_tready,
  // table_index[17:0], table_blue, table_green, table_red, pixel_blue,
  // pixel_green, pixel_red, mask_blue, mask_green, mask_red, zero pad
  input  logic [IN_W-1:0]   in_tdata,
  // kind
  input  logic              in_tuser,
  // result stream
  output logic              out_tvalid,
  input  logic              out_tready,
  // out_blue, out_green, out_red
  output logic [OUT_W-1:0]  out_tdata,
  // configuration
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  localparam int DEPTH  = TABLE_SIDE * TABLE_SIDE;
  localparam int AW     = $clog2(DEPTH);
  localparam int STAGES = 6;

  // input field unpacking
  logic [IDX_W-1:0] table_index;
  logic [CH_W-1:0]  table_blue, table_green, table_red;
  logic [CH_W-1:0]  pixel_blue, pixel_green, pixel_red;
  logic [CH_W-1:0]  mask_blue, mask_green, mask_red;

  assign table_index = in_tdata[17:0];
  assign table_blue  = in_tdata[25:18];
  assign table_green = in_tdata[33:26];
  assign table_red   = in_tdata[41:34];
  assign pixel_blue  = in_tdata[49:42];
  assign pixel_green = in_tdata[57:50];
  assign pixel_red   = in_tdata[65:58];
  assign mask_blue   = in_tdata[73:66];
  assign mask_green  = in_tdata[81:74];
  assign mask_red    = in_tdata[89:82];

  // pipeline control: stage k loads when empty or when stage k+1 loads
  logic [STAGES:1]   v_r, v_nxt;
  logic [STAGES+1:1] en;
  logic              accept;
  logic              pixel_in;
  stage_en_t         chan_en;

  always_comb begin
    en[STAGES+1] = out_tready;
    for (int k = STAGES; k >= 1; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_tready = en[1];
  assign accept    = in_tvalid && in_tready;
  assign pixel_in  = accept && (in_tuser == KIND_PIXEL);

  always_comb begin
    v_nxt = v_r;
    if (en[1]) begin
      v_nxt[1] = pixel_in;
    end
    for (int k = 2; k <= STAGES; k++) begin
      if (en[k]) begin
        v_nxt[k] = v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign chan_en = '{s2: en[2], s3: en[3], s4: en[4], s5: en[5], s6: en[6]};

  // table addressing: 64-cube folded into the square table
  logic [8:0]    tbl_row, tbl_col;
  logic [AW-1:0] rd_addr, wr_addr;

  assign tbl_row = {pixel_blue[7:5], pixel_green[7:2]};
  assign tbl_col = {pixel_blue[4:2], pixel_red[7:2]};
  assign rd_addr = AW'(32'(tbl_row) * 32'(TABLE_SIDE) + 32'(tbl_col));
  assign wr_addr = AW'(table_index);

  logic [ENTRY_W-1:0] lut_entry;

  lcg_table #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_table (
    .clk   (clk),
    .we    (accept && (in_tuser == KIND_TABLE)),
    .waddr (wr_addr),
    .wdata ({table_red, table_green, table_blue}),
    .re    (pixel_in),
    .raddr (rd_addr),
    .rdata (lut_entry)
  );

  // stage 1: source pixel and mask sum, beside the table read
  logic [CH_W-1:0] src_b1_r, src_g1_r, src_r1_r;
  logic [9:0]      msum1_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      src_b1_r <= pixel_blue;
      src_g1_r <= pixel_green;
      src_r1_r <= pixel_red;
      msum1_r  <= 10'(mask_blue) + 10'(mask_green) + 10'(mask_red);
    end
  end

  // stage 2: alpha is the mask mean, divide by 3 through a reciprocal
  logic [19:0]     div3;
  logic [CH_W-1:0] alpha2_r;

  assign div3 = 20'(msum1_r) * 20'(DIV3_MUL);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      alpha2_r <= div3[18:11];
    end
  end

  // configuration register
  logic [PCT_W-1:0] pct;

  lcg_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .pct     (pct)
  );

  // stages 2 to 6, one lane per channel
  logic [CH_W-1:0] res_b, res_g, res_r;

  lcg_chan u_chan_b (
    .clk    (clk),
    .en     (chan_en),
    .src    (src_b1_r),
    .lut    (lut_entry[7:0]),
    .alpha  (alpha2_r),
    .pct    (pct),
    .result (res_b)
  );

  lcg_chan u_chan_g (
    .clk    (clk),
    .en     (chan_en),
    .src    (src_g1_r),
    .lut    (lut_entry[15:8]),
    .alpha  (alpha2_r),
    .pct    (pct),
    .result (res_g)
  );

  lcg_chan u_chan_r (
    .clk    (clk),
    .en     (chan_en),
    .src    (src_r1_r),
    .lut    (lut_entry[23:16]),
    .alpha  (alpha2_r),
    .pct    (pct),
    .result (res_r)
  );

  assign out_tvalid = v_r[STAGES];
  assign out_tdata  = {res_r, res_g, res_b};

`ifndef NO_ASSERTIONS
  // a table load never enters the result pipeline
  a_load_no_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_tuser == KIND_TABLE)) |=> !v_r[1])
    else $error("table load produced a pipeline beat");

  // a held stage keeps its pixel
  a_stall_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[3] && !en[3]) |=> v_r[3])
    else $error("stalled stage lost its pixel");

  // input backpressure only when every stage is occupied
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (&v_r))
    else $error("input stalled with a free stage");

  // a pixel in the result register leaves or stays, it never vanishes
  a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[STAGES] && !out_tready) |=> (v_r[STAGES] && $stable(out_tdata)))
    else $error("stalled result changed");

  // clamped percent never exceeds full scale
  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    pct <= PCT_MAX)
    else $error("intensity above full scale");
`endif

endmodule
